// ===== src/mfs_pkg.sv =====
package mfs_pkg;

  localparam int MAX_USERS   = 1024;
  localparam int MAX_ITEMS   = 1024;
  localparam int MAX_FACTORS = 16;

  localparam int WORD_W = 16;
  localparam int ROW_W  = 10;
  localparam int FAC_W  = 4;
  localparam int ADDR_W = ROW_W + FAC_W;
  localparam int TABLE_DEPTH = MAX_USERS * MAX_FACTORS;

  localparam int ACC_W  = 36;
  localparam int PRED_W = 24;
  localparam int ERR_W  = 25;
  localparam int SQ_W   = 47;
  localparam int G_W    = 38;
  localparam int MA_W   = 40;
  localparam int MB_W   = 25;
  localparam int PROD_W = MA_W + MB_W;

  localparam logic [1:0] CMD_LOAD_USER = 2'd0;
  localparam logic [1:0] CMD_LOAD_ITEM = 2'd1;
  localparam logic [1:0] CMD_TRAIN     = 2'd2;
  localparam logic [1:0] CMD_PREDICT   = 2'd3;

  localparam logic REG_LEARNING_RATE  = 1'b0;
  localparam logic REG_FACTORS_IN_USE = 1'b1;

  localparam logic [15:0] LEARNING_RATE_RESET = 16'd66;
  localparam logic [4:0]  FACTORS_RESET       = 5'd16;

  typedef struct packed {
    logic [1:0]               command;
    logic [ROW_W-1:0]         user_index;
    logic [ROW_W-1:0]         item_index;
    logic [FAC_W-1:0]         factor_index;
    logic signed [WORD_W-1:0] factor_value;
    logic [14:0]              rating;
  } mfs_in_t;

  typedef struct packed {
    logic signed [31:0] prediction;
    logic signed [31:0] error;
    logic [62:0]        squared_error;
  } mfs_out_t;

endpackage

// ===== src/mfs_ram.sv =====
module mfs_ram import mfs_pkg::*; (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic signed [WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0]        raddr,
  output logic signed [WORD_W-1:0] rdata
);

  logic signed [WORD_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mfs_mul.sv =====
module mfs_mul import mfs_pkg::*; (
  input  logic                     clk,
  input  logic signed [MA_W-1:0]   a,
  input  logic signed [MB_W-1:0]   b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ===== src/matrix_factorization_sgd_engine.sv =====
// Funk SVD training engine with user and item factor tables of 1024 rows by
// 16 signed Q4.12 words each, one table read port and one multiplier shared by
// all passes. Load commands are taken in any cycle while busy is low and give
// an all-zero result on done in the next cycle. A predict item holds busy for
// the dot product alone, a train item also for the error, square and gradient
// steps and the user and item row updates. The dot product and each row update
// walk the factors in use (at most 16) once through the table read, the
// registered multiplier and the accumulate or write-back stage. The result
// is on the result port for the single cycle in which done is high, and the
// receiver must take it then. The tables are not cleared by reset, so every
// word that a train or predict item reads must have been loaded first.
module matrix_factorization_sgd_engine import mfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  mfs_in_t     item,
  output logic        done,
  output mfs_out_t    result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DOT  = 3'd1;
  localparam logic [2:0] ST_ERR  = 3'd2;
  localparam logic [2:0] ST_LRM  = 3'd3;
  localparam logic [2:0] ST_GRD  = 3'd4;
  localparam logic [2:0] ST_UPDU = 3'd5;
  localparam logic [2:0] ST_UPDV = 3'd6;

  logic [2:0]               state;
  logic [15:0]              learning_rate;
  logic [4:0]               factors_in_use;
  logic [ROW_W-1:0]         urow;
  logic [ROW_W-1:0]         irow;
  logic [14:0]              rating;
  logic                     train;
  logic [4:0]               kk;
  logic                     s1_valid;
  logic                     s2_valid;
  logic [FAC_W-1:0]         s1_k;
  logic [FAC_W-1:0]         s2_k;
  logic signed [WORD_W-1:0] s2_old;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PRED_W-1:0] pred;
  logic signed [ERR_W-1:0]  err;
  logic [SQ_W-1:0]          sq;
  logic signed [G_W-1:0]    g;

  logic [4:0]               nf;
  logic                     accept;
  logic                     is_load;
  logic                     in_pass;
  logic                     issue;
  logic                     pass_end;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [PRED_W-1:0] pred_w;
  logic signed [ERR_W-1:0]  err_w;
  logic signed [41:0]       g_rnd;
  logic signed [52:0]       upd_rnd;
  logic signed [29:0]       upd_sum;
  logic signed [WORD_W-1:0] new_word;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] p;

  logic                     u_we;
  logic [ADDR_W-1:0]        u_waddr;
  logic signed [WORD_W-1:0] u_wdata;
  logic signed [WORD_W-1:0] u_rdata;
  logic                     v_we;
  logic [ADDR_W-1:0]        v_waddr;
  logic signed [WORD_W-1:0] v_wdata;
  logic signed [WORD_W-1:0] v_rdata;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign is_load  = (item.command == CMD_LOAD_USER) || (item.command == CMD_LOAD_ITEM);
  assign nf       = (factors_in_use > 5'(MAX_FACTORS)) ? 5'(MAX_FACTORS) : factors_in_use;
  assign in_pass  = (state == ST_DOT) || (state == ST_UPDU) || (state == ST_UPDV);
  assign issue    = in_pass && (kk < nf);
  assign pass_end = in_pass && !issue && !s1_valid && !s2_valid;

  assign acc_rnd = acc + ACC_W'(2048);
  assign pred_w  = acc_rnd[ACC_W-1:12];
  assign err_w   = ERR_W'($signed({1'b0, rating})) - ERR_W'(pred);
  assign g_rnd   = p[41:0] + 42'sd8;
  assign upd_rnd = p[52:0] + 53'sd8388608;
  assign upd_sum = 30'(s2_old) + 30'($signed(upd_rnd[52:24]));

  always_comb begin
    if (upd_sum > 30'sd32767) begin
      new_word = 16'sh7fff;
    end else if (upd_sum < -30'sd32768) begin
      new_word = 16'sh8000;
    end else begin
      new_word = upd_sum[WORD_W-1:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_DOT: begin
        mul_a = MA_W'(u_rdata);
        mul_b = MB_W'(v_rdata);
      end
      ST_LRM: begin
        mul_a = MA_W'(err);
        mul_b = err;
      end
      ST_GRD: begin
        mul_a = MA_W'(err);
        mul_b = $signed({8'b0, learning_rate, 1'b0});
      end
      ST_UPDU: begin
        mul_a = MA_W'(g);
        mul_b = MB_W'(v_rdata);
      end
      ST_UPDV: begin
        mul_a = MA_W'(g);
        mul_b = MB_W'(u_rdata);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign u_we    = (accept && item.command == CMD_LOAD_USER) || (state == ST_UPDU && s2_valid);
  assign u_waddr = (state == ST_UPDU) ? {urow, s2_k} : {item.user_index, item.factor_index};
  assign u_wdata = (state == ST_UPDU) ? new_word : item.factor_value;
  assign v_we    = (accept && item.command == CMD_LOAD_ITEM) || (state == ST_UPDV && s2_valid);
  assign v_waddr = (state == ST_UPDV) ? {irow, s2_k} : {item.item_index, item.factor_index};
  assign v_wdata = (state == ST_UPDV) ? new_word : item.factor_value;

  mfs_ram u_user_table (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .raddr ({urow, kk[FAC_W-1:0]}),
    .rdata (u_rdata)
  );

  mfs_ram u_item_table (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr ({irow, kk[FAC_W-1:0]}),
    .rdata (v_rdata)
  );

  mfs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  always_ff @(posedge clk) begin
    s1_k   <= kk[FAC_W-1:0];
    s2_k   <= s1_k;
    s2_old <= (state == ST_UPDU) ? u_rdata : v_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      done           <= 1'b0;
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      learning_rate  <= LEARNING_RATE_RESET;
      factors_in_use <= FACTORS_RESET;
    end else begin
      done     <= 1'b0;
      s1_valid <= issue;
      s2_valid <= s1_valid;
      if (cfg_we) begin
        case (cfg_index)
          REG_LEARNING_RATE:  learning_rate  <= cfg_data;
          REG_FACTORS_IN_USE: factors_in_use <= cfg_data[4:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_load) begin
              done   <= 1'b1;
              result <= '0;
            end else begin
              urow   <= item.user_index;
              irow   <= item.item_index;
              rating <= item.rating;
              train  <= (item.command == CMD_TRAIN);
              kk     <= '0;
              acc    <= '0;
              state  <= ST_DOT;
            end
          end
        end
        ST_DOT: begin
          if (issue) begin
            kk <= kk + 5'd1;
          end
          if (s2_valid) begin
            acc <= acc + ACC_W'(p);
          end
          if (pass_end) begin
            pred <= pred_w;
            if (train) begin
              state <= ST_ERR;
            end else begin
              result.prediction    <= 32'(pred_w);
              result.error         <= '0;
              result.squared_error <= '0;
              done                 <= 1'b1;
              state                <= ST_IDLE;
            end
          end
        end
        ST_ERR: begin
          err   <= err_w;
          state <= ST_LRM;
        end
        ST_LRM: begin
          state <= ST_GRD;
        end
        ST_GRD: begin
          sq    <= p[SQ_W-1:0];
          state <= ST_UPDU;
          kk    <= '0;
        end
        ST_UPDU: begin
          if (issue) begin
            kk <= kk + 5'd1;
          end
          if (pass_end) begin
            kk    <= '0;
            state <= ST_UPDV;
          end
        end
        ST_UPDV: begin
          if (issue) begin
            kk <= kk + 5'd1;
          end
          if (pass_end) begin
            result.prediction    <= 32'(pred);
            result.error         <= 32'(err);
            result.squared_error <= 63'(sq);
            done                 <= 1'b1;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The gradient is taken in the cycle after the squared error leaves the multiplier.
  always_ff @(posedge clk) begin
    if (state == ST_UPDU && !s1_valid && !s2_valid && kk == 5'd0) begin
      g <= g_rnd[41:4];
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a command is still in progress");

  a_load_done: assert property (@(posedge clk) disable iff (rst)
    (accept && is_load) |=> done)
    else $error("load command gave no result in the next cycle");

  a_pipe_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!s1_valid && !s2_valid))
    else $error("factor pipeline active while idle");

  a_kk_bound: assert property (@(posedge clk) disable iff (rst) in_pass |-> (kk <= nf))
    else $error("factor counter ran past the factors in use");

endmodule

// ===== bench/matrix_factorization_sgd_engine_test.sv =====
module matrix_factorization_sgd_engine_test;
  import mfs_pkg::*;

  localparam longint PRED_MIN = -(longint'(1) <<< 31);
  localparam longint PRED_MAX = (longint'(1) <<< 31) - 1;
  localparam longint WORD_MIN = -32768;
  localparam longint WORD_MAX = 32767;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  mfs_in_t     item = '0;
  logic        done;
  mfs_out_t    result;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_LEARNING_RATE;
  logic [15:0] cfg_data = '0;

  matrix_factorization_sgd_engine dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic signed [WORD_W-1:0] user_words [0:TABLE_DEPTH-1];
  logic signed [WORD_W-1:0] item_words [0:TABLE_DEPTH-1];
  logic [15:0] rate_now = LEARNING_RATE_RESET;
  logic [4:0]  factors_now = FACTORS_RESET;

  bit loaded_word [0:1][0:TABLE_DEPTH-1];
  bit row_ready [0:1][0:MAX_USERS-1];
  int user_pool [$];
  int item_pool [$];

  mfs_in_t  command_queue [$];
  mfs_out_t predicted_outputs [$];
  mfs_out_t want_out;
  int gap_left = 0;
  int burst_left = 1;
  int mismatches = 0;

  function automatic longint round_shift(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic mfs_out_t sgd_command_result(mfs_in_t c);
    mfs_out_t r;
    longint acc, pred, err, g, w;
    int ubase, ibase, nf, k;
    r = '0;
    ubase = int'(c.user_index) * MAX_FACTORS;
    ibase = int'(c.item_index) * MAX_FACTORS;
    nf = factors_now > MAX_FACTORS ? MAX_FACTORS : int'(factors_now);
    case (c.command)
      CMD_LOAD_USER: begin
        user_words[ubase + int'(c.factor_index)] = c.factor_value;
      end
      CMD_LOAD_ITEM: begin
        item_words[ibase + int'(c.factor_index)] = c.factor_value;
      end
      default: begin
        acc = 0;
        for (k = 0; k < nf; k++)
          acc += longint'(user_words[ubase + k]) * longint'(item_words[ibase + k]);
        pred = clamp(round_shift(acc, 12), PRED_MIN, PRED_MAX);
        r.prediction = 32'(pred);
        if (c.command == CMD_TRAIN) begin
          err = clamp(longint'(c.rating) - pred, PRED_MIN, PRED_MAX);
          r.error = 32'(err);
          r.squared_error = 63'(err * err);
          g = round_shift(err * (longint'(rate_now) * 2), 4);
          for (k = 0; k < nf; k++) begin
            w = longint'(user_words[ubase + k]) +
                round_shift(g * longint'(item_words[ibase + k]), 24);
            user_words[ubase + k] = 16'(clamp(w, WORD_MIN, WORD_MAX));
          end
          for (k = 0; k < nf; k++) begin
            w = longint'(item_words[ibase + k]) +
                round_shift(g * longint'(user_words[ubase + k]), 24);
            item_words[ibase + k] = 16'(clamp(w, WORD_MIN, WORD_MAX));
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic mfs_in_t scrambled();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(mfs_in_t)-1:0];
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 16383) - 8192);
    endcase
  endfunction

  function automatic logic [14:0] pick_rating();
    case ($urandom_range(0, 7))
      0: return 15'd0;
      1: return 15'h7FFF;
      2: return 15'($urandom);
      default: return 15'($urandom_range(0, 5 * 4096));
    endcase
  endfunction

  task automatic push_load(input bit side, input int row, input int pos,
                           input logic [15:0] word);
    mfs_in_t c;
    bit full;
    int k;
    c = scrambled();
    c.command = side ? CMD_LOAD_ITEM : CMD_LOAD_USER;
    c.factor_index = FAC_W'(pos);
    c.factor_value = word;
    if (side) c.item_index = ROW_W'(row);
    else c.user_index = ROW_W'(row);
    loaded_word[side][row * MAX_FACTORS + pos] = 1'b1;
    full = 1'b1;
    for (k = 0; k < MAX_FACTORS; k++)
      full &= loaded_word[side][row * MAX_FACTORS + k];
    if (full && !row_ready[side][row]) begin
      row_ready[side][row] = 1'b1;
      if (side) item_pool = {item_pool, row};
      else user_pool = {user_pool, row};
    end
    command_queue = {command_queue, c};
  endtask

  task automatic push_row(input bit side, input int row, input bit fixed,
                          input logic [15:0] word);
    int k;
    for (k = 0; k < MAX_FACTORS; k++)
      push_load(side, row, k, fixed ? word : pick_word());
  endtask

  task automatic push_use(input logic [1:0] cmd, input int urow, input int irow,
                          input logic [14:0] score);
    mfs_in_t c;
    c = scrambled();
    c.command = cmd;
    c.user_index = ROW_W'(urow);
    c.item_index = ROW_W'(irow);
    c.rating = score;
    command_queue = {command_queue, c};
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (command_queue.size() != 0 || start || busy || predicted_outputs.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LEARNING_RATE) rate_now = val;
    else factors_now = val[4:0];
    @(negedge clk);
  endtask

  task automatic random_phase(input int n);
    int pushed, r, u, v, row;
    bit side;
    logic [14:0] score;
    pushed = 0;
    while (pushed < n) begin
      r = $urandom_range(0, 99);
      side = $urandom_range(0, 1);
      if (r < 8) begin
        row = $urandom_range(0, side ? MAX_ITEMS - 1 : MAX_USERS - 1);
        push_load(side, row, $urandom_range(0, MAX_FACTORS - 1), pick_word());
        pushed++;
      end else if (r < 20) begin
        row = side ? item_pool[$urandom_range(0, item_pool.size() - 1)]
                   : user_pool[$urandom_range(0, user_pool.size() - 1)];
        push_load(side, row, $urandom_range(0, MAX_FACTORS - 1), pick_word());
        pushed++;
      end else if (r < 21) begin
        push_row(side, $urandom_range(0, MAX_USERS - 1), 1'b0, '0);
        pushed += MAX_FACTORS;
      end else begin
        u = user_pool[$urandom_range(0, user_pool.size() - 1)];
        v = item_pool[$urandom_range(0, item_pool.size() - 1)];
        if (r < 26) begin
          score = pick_rating();
          repeat (6) push_use(CMD_TRAIN, u, v, score);
          pushed += 6;
        end else if (r < 70) begin
          push_use(CMD_TRAIN, u, v, pick_rating());
          pushed++;
        end else begin
          push_use(CMD_PREDICT, u, v, pick_rating());
          pushed++;
        end
      end
    end
  endtask

  task automatic flag_field(input string what, input logic [63:0] want,
                            input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch in %s: expected 0x%h, got 0x%h", what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predicted_outputs = {predicted_outputs, sgd_command_result(item)};
      if (start && busy) begin
        // The current item is held until the block takes it.
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (command_queue.size() != 0) begin
        item <= command_queue.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = 0;
            8, 9: gap_left = $urandom_range(20, 90);
            default: gap_left = $urandom_range(1, 8);
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (predicted_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result with none expected: 0x%h", result);
      end else begin
        want_out = predicted_outputs.pop_front();
        if (result.prediction !== want_out.prediction)
          flag_field("prediction", want_out.prediction, result.prediction);
        if (result.error !== want_out.error)
          flag_field("error", want_out.error, result.error);
        if (result.squared_error !== want_out.squared_error)
          flag_field("squared_error", want_out.squared_error, result.squared_error);
      end
    end
  end

  initial begin
    int phase;
    logic [15:0] rate;
    logic [4:0] count;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_row(1'b0, 0, 1'b1, 16'h7FFF);
    push_row(1'b0, MAX_USERS - 1, 1'b1, 16'h8000);
    push_row(1'b0, 341, 1'b0, '0);
    push_row(1'b0, 682, 1'b0, '0);
    push_row(1'b1, 0, 1'b1, 16'h7FFF);
    push_row(1'b1, MAX_ITEMS - 1, 1'b1, 16'h8000);
    push_row(1'b1, 682, 1'b0, '0);
    push_row(1'b1, 341, 1'b0, '0);
    push_use(CMD_PREDICT, 0, 0, 15'h7FFF);
    push_use(CMD_PREDICT, MAX_USERS - 1, 0, 15'd0);
    push_use(CMD_PREDICT, MAX_USERS - 1, MAX_ITEMS - 1, 15'd0);
    push_use(CMD_TRAIN, 341, 682, 15'd0);
    push_use(CMD_TRAIN, 341, 682, 15'h7FFF);
    push_use(CMD_TRAIN, 0, MAX_ITEMS - 1, 15'h7FFF);
    push_use(CMD_PREDICT, 341, 682, 15'd0);

    wait_idle();
    write_reg(REG_LEARNING_RATE, 16'hFFFF);
    write_reg(REG_FACTORS_IN_USE, 16'h001F);
    push_use(CMD_TRAIN, 0, 0, 15'd0);
    push_use(CMD_TRAIN, MAX_USERS - 1, 0, 15'h7FFF);
    push_use(CMD_TRAIN, 682, 341, 15'h7FFF);
    push_use(CMD_PREDICT, 0, 0, 15'd0);

    wait_idle();
    write_reg(REG_FACTORS_IN_USE, 16'hFFE0);
    push_use(CMD_PREDICT, 682, 341, 15'd0);
    push_use(CMD_TRAIN, 682, 341, 15'h7FFF);

    wait_idle();
    write_reg(REG_LEARNING_RATE, 16'h0000);
    write_reg(REG_FACTORS_IN_USE, 16'd1);
    push_use(CMD_TRAIN, 341, 682, 15'h7FFF);
    push_use(CMD_PREDICT, 341, 682, 15'd0);

    for (phase = 0; phase < 6; phase++) begin
      wait_idle();
      if (phase == 0) begin
        rate = LEARNING_RATE_RESET;
        count = FACTORS_RESET;
      end else begin
        case ($urandom_range(0, 4))
          0: rate = 16'h0000;
          1: rate = 16'hFFFF;
          2: rate = 16'($urandom);
          default: rate = 16'($urandom_range(1, 2000));
        endcase
        case ($urandom_range(0, 5))
          0: count = 5'd0;
          1: count = 5'($urandom_range(MAX_FACTORS + 1, 31));
          default: count = 5'($urandom_range(1, MAX_FACTORS));
        endcase
      end
      write_reg(REG_LEARNING_RATE, rate);
      write_reg(REG_FACTORS_IN_USE, {11'($urandom), count});
      random_phase(200);
    end

    wait_idle();
    repeat (70) @(negedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mfs_pkg.sv
src/mfs_ram.sv
src/mfs_mul.sv
src/matrix_factorization_sgd_engine.sv
bench/matrix_factorization_sgd_engine_test.sv
